/* rtl/sine_table_sample_generator_core_assert.svh */
// Assertion macros for the sine table sample generator.
// No dependencies; included by the top level only.
`ifndef SINE_TABLE_SAMPLE_GENERATOR_CORE_ASSERT_SVH
`define SINE_TABLE_SAMPLE_GENERATOR_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define STSG_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define STSG_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/stsg_pkg.sv */
// Constants and types for the sine table sample generator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package stsg_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_TABLE_LENGTH  = 2'd0;
    localparam logic [1:0] CFG_AMPLITUDE_MV  = 2'd1;
    localparam logic [1:0] CFG_PHASE_DEGREES = 2'd2;

    localparam logic [8:0]  RST_TABLE_LENGTH  = 9'd256;
    localparam logic [10:0] RST_AMPLITUDE_MV  = 11'd1000;
    localparam logic [8:0]  RST_PHASE_DEGREES = 9'd0;

    localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

    // Taylor divisors (innermost first) and floor(2^32 / d)
    localparam int NPOLY = 5;
    localparam logic [NPOLY-1:0][6:0] POLY_DIV = {7'd6, 7'd20, 7'd42, 7'd72, 7'd110};
    localparam logic [NPOLY-1:0][31:0] POLY_RECIP = {
        32'd715827882, 32'd214748364, 32'd102261126, 32'd59652323, 32'd39045157
    };

    localparam logic [11:0] DAC_FULL   = 12'd4095;
    localparam logic [11:0] VREF_MV    = 12'd3300;
    localparam logic [20:0] VREF_RECIP = 21'd1301505;   // floor(2^32 / 3300)

    typedef struct packed {
        logic [30:0]             x;
        logic                    neg;
        logic [NPOLY-1:0][31:0]  d;      // x^2 / divisor
        logic [30:0]             t;      // nested polynomial term
    } t_poly;

endpackage

`default_nettype wire

/* rtl/sine_table_sample_generator_core.sv */
// Throughput: one sample per cycle while the master side accepts results; the phase angle comes from
// a 51-step long division (three steps per stage over 17 stages), then a chain of sine term stages.
// Stages with no valid item are filled while later ones stall.
// Reset (synchronous, active low) clears all valid bits and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none
`include "sine_table_sample_generator_core_assert.svh"

module sine_table_sample_generator_core #(
    parameter int TABLE_DEPTH        = 256,
    parameter int SINE_FRACTION_BITS = 15
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [10:0] i_cfg_wdata,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [7:0] sample_index
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [15:0]      o_m_axis_tdata    // [11:0] sample_code, [15:12] zero
);

    localparam int FB      = SINE_FRACTION_BITS;
    localparam int NUMW    = 19;
    localparam int DIV_PER = 3;
    localparam int DIV_ST  = (NUMW + 32) / DIV_PER;
    localparam int ST_FOLD = DIV_ST + 1;
    localparam int ST_X    = ST_FOLD + 1;
    localparam int ST_X2   = ST_X + 1;
    localparam int ST_RQ   = ST_X2 + 1;
    localparam int ST_CQ   = ST_RQ + 1;      // followed by NPOLY term stages
    localparam int ST_S    = ST_CQ + stsg_pkg::NPOLY + 1;
    localparam int ST_LV   = ST_S + 1;
    localparam int ST_P    = ST_LV + 1;
    localparam int ST_V    = ST_P + 1;
    localparam int ST_Q    = ST_V + 1;
    localparam int ST_OUT  = ST_Q + 1;
    localparam int NST     = ST_OUT + 1;
    localparam int PW      = FB + 13;
    localparam logic [31:0] RND   = 32'(1) << (29 - FB);
    localparam logic [FB+1:0] ONE_F = (FB + 2)'(1) << FB;

    // configuration
    logic [8:0]  r_table_length;
    logic [10:0] r_amplitude_mv;
    logic [8:0]  r_phase_degrees;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_length  <= stsg_pkg::RST_TABLE_LENGTH;
            r_amplitude_mv  <= stsg_pkg::RST_AMPLITUDE_MV;
            r_phase_degrees <= stsg_pkg::RST_PHASE_DEGREES;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                stsg_pkg::CFG_TABLE_LENGTH:  r_table_length  <= i_cfg_wdata[8:0];
                stsg_pkg::CFG_AMPLITUDE_MV:  r_amplitude_mv  <= i_cfg_wdata;
                stsg_pkg::CFG_PHASE_DEGREES: r_phase_degrees <= i_cfg_wdata[8:0];
                default: ;
            endcase
        end
    end

    logic [8:0]  c_len_lo;
    logic [8:0]  c_len;
    logic [17:0] c_den;

    always_comb begin
        c_len_lo = (r_table_length < 9'd2) ? 9'd2 : r_table_length;
        c_len    = ({23'd0, c_len_lo} > 32'(TABLE_DEPTH)) ? 9'(TABLE_DEPTH) : c_len_lo;
        c_den    = 18'(c_len) * 18'd360;
    end

    // stage handshake: a stage loads when empty or when the next one moves
    logic [NST-1:0] r_v;
    logic [NST-1:0] c_en;

    always_comb begin
        c_en[NST-1] = !r_v[NST-1] || i_m_axis_tready;
        for (int k = NST - 2; k >= 0; k--) begin
            c_en[k] = !r_v[k] || c_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (c_en[0]) r_v[0] <= i_s_axis_tvalid;
            for (int k = 1; k < NST; k++) begin
                if (c_en[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    assign o_s_axis_tready = c_en[0];

    // angle numerator, then long division of num * 2^32 by 360 * length
    logic [17:0]     r_rem [0:DIV_ST];
    logic [NUMW-1:0] r_nsh [0:DIV_ST];
    logic [31:0]     r_quo [0:DIV_ST];

    always_ff @(posedge i_clk) begin
        if (c_en[0]) begin
            r_rem[0] <= '0;
            r_quo[0] <= '0;
            r_nsh[0] <= NUMW'(i_s_axis_tdata) * NUMW'(360)
                      + NUMW'(r_phase_degrees) * NUMW'(c_len);
        end
    end

    for (genvar g = 1; g <= DIV_ST; g++) begin : g_div
        logic [17:0]     c_rem;
        logic [NUMW-1:0] c_nsh;
        logic [31:0]     c_quo;
        logic [18:0]     c_r2;

        always_comb begin
            c_rem = r_rem[g-1];
            c_nsh = r_nsh[g-1];
            c_quo = r_quo[g-1];
            c_r2  = '0;
            for (int s = 0; s < DIV_PER; s++) begin
                c_r2  = {c_rem, c_nsh[NUMW-1]};
                c_nsh = {c_nsh[NUMW-2:0], 1'b0};
                if (c_r2 >= {1'b0, c_den}) begin
                    c_rem = 18'(c_r2 - {1'b0, c_den});
                    c_quo = {c_quo[30:0], 1'b1};
                end else begin
                    c_rem = c_r2[17:0];
                    c_quo = {c_quo[30:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (c_en[g]) begin
                r_rem[g] <= c_rem;
                r_nsh[g] <= c_nsh;
                r_quo[g] <= c_quo;
            end
        end
    end

    // quadrant fold and scaling to radians
    logic [30:0] r_u;
    logic        r_neg_u;
    logic [30:0] r_x_x;
    logic        r_neg_x;
    logic [30:0] r_x_x2;
    logic [31:0] r_x2_x2;
    logic        r_neg_x2;
    logic [stsg_pkg::NPOLY-1:0][31:0] r_q0;
    logic [31:0] r_x2_rq;
    logic [30:0] r_x_rq;
    logic        r_neg_rq;

    always_ff @(posedge i_clk) begin
        if (c_en[ST_FOLD]) begin
            r_neg_u <= r_quo[DIV_ST][31];
            r_u     <= r_quo[DIV_ST][30]
                     ? 31'(stsg_pkg::Q30_ONE - {1'b0, r_quo[DIV_ST][29:0]})
                     : {1'b0, r_quo[DIV_ST][29:0]};
        end
        if (c_en[ST_X]) begin
            r_neg_x <= r_neg_u;
            r_x_x   <= 31'((62'(r_u) * 62'(stsg_pkg::HALF_PI_Q30)) >> 30);
        end
        if (c_en[ST_X2]) begin
            r_neg_x2 <= r_neg_x;
            r_x_x2   <= r_x_x;
            r_x2_x2  <= 32'((62'(r_x_x) * 62'(r_x_x)) >> 30);
        end
        if (c_en[ST_RQ]) begin
            r_neg_rq <= r_neg_x2;
            r_x_rq   <= r_x_x2;
            r_x2_rq  <= r_x2_x2;
            for (int k = 0; k < stsg_pkg::NPOLY; k++) begin
                r_q0[k] <= 32'((64'(r_x2_x2) * 64'(stsg_pkg::POLY_RECIP[k])) >> 32);
            end
        end
    end

    // reciprocal estimate is low by at most one
    stsg_pkg::t_poly r_pl [0:stsg_pkg::NPOLY];
    stsg_pkg::t_poly c_cq;

    always_comb begin
        logic [31:0] rr;
        rr        = '0;
        c_cq      = '0;
        c_cq.x    = r_x_rq;
        c_cq.neg  = r_neg_rq;
        for (int k = 0; k < stsg_pkg::NPOLY; k++) begin
            rr = r_x2_rq - 32'(64'(r_q0[k]) * 64'(stsg_pkg::POLY_DIV[k]));
            c_cq.d[k] = (rr >= 32'(stsg_pkg::POLY_DIV[k])) ? r_q0[k] + 32'd1 : r_q0[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_en[ST_CQ]) r_pl[0] <= c_cq;
    end

    for (genvar p = 1; p <= stsg_pkg::NPOLY; p++) begin : g_term
        stsg_pkg::t_poly n_pl;

        always_comb begin
            n_pl = r_pl[p-1];
            if (p == 1) begin
                n_pl.t = 31'(stsg_pkg::Q30_ONE - r_pl[p-1].d[p-1][30:0]);
            end else begin
                n_pl.t = 31'(33'(stsg_pkg::Q30_ONE)
                       - 33'((63'(r_pl[p-1].d[p-1]) * 63'(r_pl[p-1].t)) >> 30));
            end
        end

        always_ff @(posedge i_clk) begin
            if (c_en[ST_CQ+p]) r_pl[p] <= n_pl;
        end
    end

    // final sine, rounding, level and DAC scaling
    logic [30:0]    r_s;
    logic           r_neg_s;
    logic [FB+1:0]  r_level;
    logic [PW-1:0]  r_p;
    logic [24:0]    r_vv;
    logic [24:0]    r_vq;
    logic [13:0]    r_cq0;
    logic [11:0]    r_code;
    logic [31:0]    c_sr;
    logic [FB+1:0]  c_sl;
    logic [PW+11:0] c_p4095;
    logic [24:0]    c_rv;
    logic [13:0]    c_code;

    always_comb begin
        c_sr    = (32'(r_s) + RND) >> (30 - FB);
        c_sl    = (c_sr > 32'(ONE_F)) ? ONE_F : (FB + 2)'(c_sr);
        c_p4095 = ((PW + 12)'(r_p) << 12) - (PW + 12)'(r_p);
        c_rv    = r_vq - 25'(r_cq0) * 25'(stsg_pkg::VREF_MV);
        c_code  = (c_rv >= 25'(stsg_pkg::VREF_MV)) ? r_cq0 + 14'd1 : r_cq0;
    end

    always_ff @(posedge i_clk) begin
        if (c_en[ST_S]) begin
            r_neg_s <= r_pl[stsg_pkg::NPOLY].neg;
            r_s     <= 31'((62'(r_pl[stsg_pkg::NPOLY].x) * 62'(r_pl[stsg_pkg::NPOLY].t)) >> 30);
        end
        if (c_en[ST_LV]) r_level <= r_neg_s ? ONE_F - c_sl : ONE_F + c_sl;
        if (c_en[ST_P])  r_p     <= PW'(r_amplitude_mv) * PW'(r_level);
        if (c_en[ST_V])  r_vv    <= 25'(c_p4095 >> FB);
        if (c_en[ST_Q]) begin
            r_vq  <= r_vv;
            r_cq0 <= 14'((46'(r_vv) * 46'(stsg_pkg::VREF_RECIP)) >> 32);
        end
        if (c_en[ST_OUT]) begin
            r_code <= (c_code > 14'(stsg_pkg::DAC_FULL)) ? stsg_pkg::DAC_FULL : c_code[11:0];
        end
    end

    assign o_m_axis_tvalid = r_v[NST-1];
    assign o_m_axis_tdata  = {4'd0, r_code};

    `STSG_ASSERT_IMP(a_full_when_stalled, i_clk, i_rst_n, !o_s_axis_tready, &r_v, "input stalled with an empty stage")
    `STSG_ASSERT_NXT(a_out_held, i_clk, i_rst_n, r_v[NST-1] && !i_m_axis_tready, r_v[NST-1], "result dropped")
    `STSG_ASSERT_NXT(a_front_held, i_clk, i_rst_n, r_v[0] && !c_en[1], r_v[0], "front stage lost an item")

endmodule

`default_nettype wire
